// ===== hdl/eac_pkg.sv =====
// Shared constants and types for the email address checker.
package eac_pkg;

    // Longest string that can still be reported valid
    localparam int MAX_LEN = 256;

    // Byte counter holds 0..MAX_LEN; stored '@' / '.' positions hold 0..MAX_LEN-1
    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CMP_W = POS_W + 1;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] idx_t;

    // One accepted input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } beat_t;

endpackage

// ===== hdl/eac_ingress.sv =====
// Input register stage: holds one byte beat until the scanner takes it.
module eac_ingress
    import eac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // last
    output logic       beat_valid,
    output beat_t      beat,
    input  logic       beat_take
);

    logic  in_valid_reg;
    beat_t beat_reg;

    // Accept a new beat when empty or when the held beat leaves this cycle
    assign s_tready   = !in_valid_reg || beat_take;
    assign beat_valid = in_valid_reg;
    assign beat       = beat_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture the payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg.ch   <= s_tdata;
            beat_reg.last <= s_tlast;
        end
    end

endmodule

// ===== hdl/eac_scan.sv =====
// Per-string scan state, rule evaluation and result register.
module eac_scan
    import eac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_valid,
    input  beat_t      beat,
    output logic       beat_take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    pos_t       position_reg, position_next;
    logic [1:0] at_count_reg, at_count_next;
    idx_t       at_pos_reg, at_pos_next;
    logic       dot_seen_reg, dot_seen_next;
    idx_t       dot_pos_reg, dot_pos_next;
    logic       failed_reg, failed_next;
    logic       out_valid_reg;
    logic       out_res_reg;
    logic       ok;
    logic       in_range;
    logic       dot_adjacent;

    // Take a beat unless it closes a string and the result slot stays full
    assign beat_take = beat_valid && (!beat.last || !out_valid_reg || m_tready);

    assign in_range     = position_reg < POS_W'(MAX_LEN);
    assign dot_adjacent = (CMP_W'(dot_pos_reg) + CMP_W'(1)) == CMP_W'(position_reg);

    // Update the tracked positions, counts and failure flag for this byte
    always_comb begin
        position_next = position_reg;
        at_count_next = at_count_reg;
        at_pos_next   = at_pos_reg;
        dot_seen_next = dot_seen_reg;
        dot_pos_next  = dot_pos_reg;
        failed_next   = failed_reg;
        if (!in_range) begin
            failed_next = 1'b1;
        end else begin
            if (beat.ch == CH_AT) begin
                if (at_count_reg != 2'd3) begin
                    at_count_next = at_count_reg + 2'd1;
                end
                at_pos_next = position_reg[IDX_W-1:0];
            end else if (beat.ch == CH_DOT) begin
                if (dot_seen_reg && dot_adjacent) begin
                    failed_next = 1'b1;
                end
                dot_seen_next = 1'b1;
                dot_pos_next  = position_reg[IDX_W-1:0];
            end else if (beat.ch == CH_SPACE) begin
                failed_next = 1'b1;
            end
            position_next = position_reg + POS_W'(1);
        end
    end

    // Judge the finished string from the updated state
    assign ok = !failed_next
             && (at_count_next == 2'd1)
             && (at_pos_next != '0)
             && dot_seen_next
             && (CMP_W'(dot_pos_next) >= CMP_W'(at_pos_next) + CMP_W'(2))
             && (CMP_W'(dot_pos_next) + CMP_W'(2) <= CMP_W'(position_next));

    // Advance scan state; clear it after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            at_count_reg <= '0;
            at_pos_reg   <= '0;
            dot_seen_reg <= 1'b0;
            dot_pos_reg  <= '0;
            failed_reg   <= 1'b0;
        end else if (beat_take) begin
            if (beat.last) begin
                position_reg <= '0;
                at_count_reg <= '0;
                at_pos_reg   <= '0;
                dot_seen_reg <= 1'b0;
                dot_pos_reg  <= '0;
                failed_reg   <= 1'b0;
            end else begin
                position_reg <= position_next;
                at_count_reg <= at_count_next;
                at_pos_reg   <= at_pos_next;
                dot_seen_reg <= dot_seen_next;
                dot_pos_reg  <= dot_pos_next;
                failed_reg   <= failed_next;
            end
        end
    end

    // Hold the result until the downstream takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (beat_take && beat.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_take && beat.last) begin
            out_res_reg <= ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg};

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= POS_W'(MAX_LEN))
        else $error("byte position exceeded its saturation limit");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_take && beat.last |=> m_tvalid)
        else $error("final beat taken without a result");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_take && beat.last |=> position_reg == '0 && at_count_reg == 2'd0
                                   && !dot_seen_reg && !failed_reg)
        else $error("scan state not cleared after final beat");

    a_dot_pos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !dot_seen_reg |-> dot_pos_reg == '0)
        else $error("dot position set without a dot seen");

endmodule

// ===== hdl/email_address_checker_top.sv =====
// Top level of the email address checker: input register feeding the scanner.
// The last byte's beat passes the input register, where a stall may hold it, then the result register to m_tvalid.
// Throughput: one byte beat per cycle, including back-to-back strings, while no result stall holds the input.
// Stalls: a final byte held in the input register waits while the previous result
// is still unaccepted, and the input holds off every new beat behind it meanwhile.
// Reset: synchronous active-low aresetn empties both stages and clears scan state.
module email_address_checker_top
    import eac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    logic  beat_valid;
    logic  beat_take;
    beat_t beat;

    eac_ingress u_ingress (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    eac_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
